FILE: design/rwhp_pkg.sv
package rwhp_pkg;

   localparam int unsigned DATA_W   = 8;
   localparam int unsigned LENGTH_W = 32;
   localparam int unsigned COUNT_W  = 5;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [COUNT_W-1:0] TAG_BYTES      = 5'd4;
   localparam logic [COUNT_W-1:0] FMT_BODY_BYTES = 5'd16;
   localparam logic [32:0]        CHUNK_HDR_BYTES = 33'd8;
   localparam logic [15:0]        PCM_FORMAT     = 16'd1;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_ERROR   = 2'd1,
      KIND_PAYLOAD = 2'd2
   } kind_type;

   // one result item as it leaves the parser
   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic [DATA_W-1:0]   payload_byte;
      logic                last_payload;
      logic [15:0]         audio_channels;
      logic [31:0]         sample_rate;
      logic [15:0]         sample_bits;
      logic [LENGTH_W-1:0] payload_offset;
      logic [LENGTH_W-1:0] payload_length;
   } result_type;

endpackage

FILE: design/rwhp_parser.sv
module rwhp_parser
   import rwhp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [DATA_W-1:0]   data_byte,
   input  logic                first_byte,
   input  logic [LENGTH_W-1:0] file_length,
   output result_type          result
);

   typedef enum logic [9:0] {
      PH_WAIT       = 10'b00_0000_0001,
      PH_RIFF_TAG   = 10'b00_0000_0010,
      PH_RIFF_SIZE  = 10'b00_0000_0100,
      PH_WAVE_TAG   = 10'b00_0000_1000,
      PH_CHUNK_ID   = 10'b00_0001_0000,
      PH_CHUNK_SIZE = 10'b00_0010_0000,
      PH_FMT_BODY   = 10'b00_0100_0000,
      PH_SKIP       = 10'b00_1000_0000,
      PH_PAYLOAD    = 10'b01_0000_0000,
      PH_DONE       = 10'b10_0000_0000
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [31:0]         pos_ff, pos_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [31:0]         tag_ff, tag_in;
   logic [31:0]         chunk_len_ff, chunk_len_in;
   logic [32:0]         skip_ff, skip_in;
   logic [15:0]         format_ff, format_in;
   logic [15:0]         channels_ff, channels_in;
   logic [31:0]         rate_ff, rate_in;
   logic [15:0]         bits_ff, bits_in;
   logic                fmt_seen_ff, fmt_seen_in;
   logic [31:0]         data_start_ff, data_start_in;
   logic [31:0]         data_len_ff, data_len_in;
   logic [31:0]         sent_ff, sent_in;

   logic                report_error;
   logic                report_header;
   logic                at_boundary;
   logic                last;
   logic [31:0]         avail;
   logic [3:0]          fmt_index;

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      tag_in        = tag_ff;
      chunk_len_in  = chunk_len_ff;
      skip_in       = skip_ff;
      format_in     = format_ff;
      channels_in   = channels_ff;
      rate_in       = rate_ff;
      bits_in       = bits_ff;
      fmt_seen_in   = fmt_seen_ff;
      data_start_in = data_start_ff;
      data_len_in   = data_len_ff;
      sent_in       = sent_ff;
      report_error  = 1'b0;
      report_header = 1'b0;
      at_boundary   = 1'b0;
      last          = 1'b0;
      avail         = '0;
      fmt_index     = count_ff[3:0];
      result        = '0;

      // restart: the flagged byte is byte zero of a new file
      if (first_byte) begin
         phase_in      = PH_RIFF_TAG;
         pos_in        = '0;
         count_in      = '0;
         tag_in        = '0;
         chunk_len_in  = '0;
         skip_in       = '0;
         format_in     = '0;
         channels_in   = '0;
         rate_in       = '0;
         bits_in       = '0;
         fmt_seen_in   = 1'b0;
         data_start_in = '0;
         data_len_in   = '0;
         sent_in       = '0;
         fmt_index     = '0;
      end

      if (phase_in == PH_PAYLOAD) begin
         last    = (sent_in + 32'd1 == data_len_in);
         sent_in = sent_in + 32'd1;
         if (last) begin
            phase_in = PH_DONE;
         end
         result.valid        = 1'b1;
         result.kind         = KIND_PAYLOAD;
         result.payload_byte = data_byte;
         result.last_payload = last;
      end else if (phase_in != PH_WAIT && phase_in != PH_DONE) begin
         pos_in = pos_in + 32'd1;
         case (phase_in)
            PH_RIFF_TAG, PH_WAVE_TAG: begin
               tag_in   = {tag_in[23:0], data_byte};
               count_in = count_in + 5'd1;
               if (count_in == TAG_BYTES) begin
                  if (tag_in != ((phase_in == PH_RIFF_TAG) ? TAG_RIFF : TAG_WAVE)) begin
                     phase_in     = PH_DONE;
                     report_error = 1'b1;
                  end else if (phase_in == PH_RIFF_TAG) begin
                     phase_in = PH_RIFF_SIZE;
                     count_in = '0;
                  end else begin
                     at_boundary = 1'b1;
                  end
               end
            end
            PH_RIFF_SIZE: begin
               count_in = count_in + 5'd1;
               if (count_in == TAG_BYTES) begin
                  phase_in = PH_WAVE_TAG;
                  count_in = '0;
                  tag_in   = '0;
               end
            end
            PH_CHUNK_ID: begin
               tag_in   = {tag_in[23:0], data_byte};
               count_in = count_in + 5'd1;
               if (count_in == TAG_BYTES) begin
                  phase_in     = PH_CHUNK_SIZE;
                  count_in     = '0;
                  chunk_len_in = '0;
               end
            end
            PH_CHUNK_SIZE: begin
               // little-endian size
               case (count_in[1:0])
                  2'd0:    chunk_len_in[7:0]   = data_byte;
                  2'd1:    chunk_len_in[15:8]  = data_byte;
                  2'd2:    chunk_len_in[23:16] = data_byte;
                  default: chunk_len_in[31:24] = data_byte;
               endcase
               count_in = count_in + 5'd1;
               if (count_in == TAG_BYTES) begin
                  count_in = '0;
                  if (tag_in == TAG_FMT) begin
                     format_in   = '0;
                     channels_in = '0;
                     rate_in     = '0;
                     bits_in     = '0;
                     phase_in    = PH_FMT_BODY;
                  end else if (tag_in == TAG_DATA) begin
                     avail         = (file_length > pos_in) ? (file_length - pos_in) : '0;
                     data_start_in = pos_in;
                     data_len_in   = (chunk_len_in <= avail) ? chunk_len_in : avail;
                     sent_in       = '0;
                     if (fmt_seen_in && format_in == PCM_FORMAT && data_len_in != '0) begin
                        phase_in      = PH_PAYLOAD;
                        report_header = 1'b1;
                     end else begin
                        phase_in     = PH_DONE;
                        report_error = 1'b1;
                     end
                  end else begin
                     // odd-sized chunks carry one pad byte
                     skip_in = {1'b0, chunk_len_in} + {32'd0, chunk_len_in[0]};
                     if (skip_in == '0) begin
                        at_boundary = 1'b1;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
            end
            PH_FMT_BODY: begin
               case (fmt_index)
                  4'd0:    format_in[7:0]    = data_byte;
                  4'd1:    format_in[15:8]   = data_byte;
                  4'd2:    channels_in[7:0]  = data_byte;
                  4'd3:    channels_in[15:8] = data_byte;
                  4'd4:    rate_in[7:0]      = data_byte;
                  4'd5:    rate_in[15:8]     = data_byte;
                  4'd6:    rate_in[23:16]    = data_byte;
                  4'd7:    rate_in[31:24]    = data_byte;
                  4'd14:   bits_in[7:0]      = data_byte;
                  4'd15:   bits_in[15:8]     = data_byte;
                  default: ;
               endcase
               count_in = count_in + 5'd1;
               if (count_in == FMT_BODY_BYTES) begin
                  fmt_seen_in = 1'b1;
                  if (chunk_len_in > 32'(FMT_BODY_BYTES)) begin
                     skip_in  = {1'b0, chunk_len_in - 32'(FMT_BODY_BYTES)};
                     phase_in = PH_SKIP;
                  end else begin
                     at_boundary = 1'b1;
                  end
               end
            end
            PH_SKIP: begin
               if (skip_in != '0) begin
                  skip_in = skip_in - 33'd1;
               end
               if (skip_in == '0) begin
                  at_boundary = 1'b1;
               end
            end
            default: ;
         endcase

         // next chunk header needs 8 bytes left in the file
         if (at_boundary) begin
            count_in = '0;
            tag_in   = '0;
            if ({1'b0, pos_in} + CHUNK_HDR_BYTES <= {1'b0, file_length}) begin
               phase_in = PH_CHUNK_ID;
            end else begin
               phase_in     = PH_DONE;
               report_error = 1'b1;
            end
         end

         // file ran out before the header concluded
         if (!report_error && !report_header && phase_in != PH_PAYLOAD &&
             phase_in != PH_DONE && pos_in >= file_length) begin
            phase_in     = PH_DONE;
            report_error = 1'b1;
         end

         if (report_error) begin
            result.valid = 1'b1;
            result.kind  = KIND_ERROR;
         end else if (report_header) begin
            result.valid          = 1'b1;
            result.kind           = KIND_HEADER;
            result.audio_channels = channels_in;
            result.sample_rate    = rate_in;
            result.sample_bits    = bits_in;
            result.payload_offset = data_start_in;
            result.payload_length = data_len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         pos_ff        <= '0;
         count_ff      <= '0;
         tag_ff        <= '0;
         chunk_len_ff  <= '0;
         skip_ff       <= '0;
         format_ff     <= '0;
         channels_ff   <= '0;
         rate_ff       <= '0;
         bits_ff       <= '0;
         fmt_seen_ff   <= 1'b0;
         data_start_ff <= '0;
         data_len_ff   <= '0;
         sent_ff       <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         count_ff      <= count_in;
         tag_ff        <= tag_in;
         chunk_len_ff  <= chunk_len_in;
         skip_ff       <= skip_in;
         format_ff     <= format_in;
         channels_ff   <= channels_in;
         rate_ff       <= rate_in;
         bits_ff       <= bits_in;
         fmt_seen_ff   <= fmt_seen_in;
         data_start_ff <= data_start_in;
         data_len_ff   <= data_len_in;
         sent_ff       <= sent_in;
      end
   end

endmodule

FILE: design/riff_wave_header_parser.sv
// riff/wave header parser with payload pass-through
//
// req channel: one file byte per item, req_first_byte marks byte zero of a
// new file and restarts the parser from any point, even mid payload.
// csr port: csr_wr_data is taken as the total file length whenever
// csr_wr_en is high; write it only while the block is idle.
// rsp channel: per byte at most one item comes out. the header yields one
// header report (kind 0, fmt fields, payload offset and clamped length) or
// one error report (kind 1); after a good header each payload byte comes out
// as kind 2, the final one with rsp_last_payload set. bytes before a first
// byte, after an error or after the last payload byte give nothing.
// path: a byte is held in the input register, then the parser state update
// writes its result into the output register.
// throughput: one byte per cycle while no result waits on a stalled receiver.
// the input register still takes a byte while a result waits on a stalled
// receiver; a further byte waits until rsp_ready frees the output register.
// reset: parser waits for a first byte, file length clears to zero.
module riff_wave_header_parser
   import rwhp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [DATA_W-1:0]   req_data_byte,
   input  logic                req_first_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [DATA_W-1:0]   rsp_payload_byte,
   output logic                rsp_last_payload,
   output logic [15:0]         rsp_audio_channels,
   output logic [31:0]         rsp_sample_rate,
   output logic [15:0]         rsp_sample_bits,
   output logic [LENGTH_W-1:0] rsp_payload_offset,
   output logic [LENGTH_W-1:0] rsp_payload_length,
   input  logic                csr_wr_en,
   input  logic [LENGTH_W-1:0] csr_wr_data
);

   // configuration
   logic [LENGTH_W-1:0] file_length_ff;

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [DATA_W-1:0]   in_byte_ff;
   logic                in_first_ff;

   // output register
   logic                out_valid_ff, out_valid_in;
   result_type          out_ff;

   result_type          result;
   logic                advance;
   logic                req_take;

   // the parser consumes the held byte once the output register can take a result
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance ? result.valid : (out_valid_ff && !rsp_ready);

   rwhp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .first_byte  (in_first_ff),
      .file_length (file_length_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= '0;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            file_length_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
      end
      if (advance && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_last_payload   = out_ff.last_payload;
   assign rsp_audio_channels = out_ff.audio_channels;
   assign rsp_sample_rate    = out_ff.sample_rate;
   assign rsp_sample_bits    = out_ff.sample_bits;
   assign rsp_payload_offset = out_ff.payload_offset;
   assign rsp_payload_length = out_ff.payload_length;

endmodule
